/* rtl/core/kmva_pkg.sv */
// Package: microcode word, control codes and program of the key matrix voice allocator.
`default_nettype none
package kmva_pkg;

    localparam int PC_W = 4;

    // stall selects
    localparam logic [1:0] STL_NONE = 2'd0;
    localparam logic [1:0] STL_IN   = 2'd1;  // wait for an input item
    localparam logic [1:0] STL_OUT  = 2'd2;  // wait until the pending event can move out

    // datapath actions
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_NOP   = 3'd1;
    localparam logic [2:0] ACT_INIT  = 3'd2;
    localparam logic [2:0] ACT_STEP  = 3'd3;
    localparam logic [2:0] ACT_GRANT = 3'd4;
    localparam logic [2:0] ACT_REL   = 3'd5;
    localparam logic [2:0] ACT_ADV   = 3'd6;
    localparam logic [2:0] ACT_FLUSH = 3'd7;

    // branch conditions
    localparam logic [2:0] C_ALWAYS      = 3'd0;
    localparam logic [2:0] C_BADCOL      = 3'd1;
    localparam logic [2:0] C_PRESS_NEW   = 3'd2;
    localparam logic [2:0] C_RELEASE_OLD = 3'd3;
    localparam logic [2:0] C_CAND_FREE   = 3'd4;
    localparam logic [2:0] C_EXHAUSTED   = 3'd5;
    localparam logic [2:0] C_LAST_ROW    = 3'd6;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_READ     = 4'd1;
    localparam logic [PC_W-1:0] PC_TEST_ON  = 4'd2;
    localparam logic [PC_W-1:0] PC_TEST_OFF = 4'd3;
    localparam logic [PC_W-1:0] PC_SEARCH   = 4'd4;
    localparam logic [PC_W-1:0] PC_GRANT    = 4'd5;
    localparam logic [PC_W-1:0] PC_RELEASE  = 4'd6;
    localparam logic [PC_W-1:0] PC_ADVANCE  = 4'd7;
    localparam logic [PC_W-1:0] PC_CHECK    = 4'd8;
    localparam logic [PC_W-1:0] PC_FLUSH    = 4'd9;

    // event kinds
    localparam logic EV_NOTE_ON  = 1'b0;
    localparam logic EV_NOTE_OFF = 1'b1;

    localparam int VOICE_OUT_W = 4;
    localparam int NOTE_W      = 7;
    localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

    typedef struct packed {
        logic [1:0]      stall;
        logic [2:0]      act;
        logic [2:0]      cond;
        logic [PC_W-1:0] t_true;
        logic [PC_W-1:0] t_false;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic bad_col;
        logic press_new;
        logic release_old;
        logic cand_free;
        logic exhausted;
        logic last_row;
        logic out_blocked;
    } t_cond;

    typedef struct packed {
        logic [2:0] act;
        logic       fire;  // step proceeds this cycle
    } t_ctl;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_IDLE:     w = '{STL_IN,   ACT_LOAD,  C_BADCOL,      PC_IDLE,    PC_READ};
            PC_READ:     w = '{STL_NONE, ACT_NOP,   C_ALWAYS,      PC_TEST_ON, PC_TEST_ON};
            PC_TEST_ON:  w = '{STL_NONE, ACT_INIT,  C_PRESS_NEW,   PC_SEARCH,  PC_TEST_OFF};
            PC_TEST_OFF: w = '{STL_NONE, ACT_NOP,   C_RELEASE_OLD, PC_RELEASE, PC_ADVANCE};
            PC_SEARCH:   w = '{STL_NONE, ACT_STEP,  C_CAND_FREE,   PC_GRANT,   PC_CHECK};
            PC_GRANT:    w = '{STL_OUT,  ACT_GRANT, C_ALWAYS,      PC_ADVANCE, PC_ADVANCE};
            PC_RELEASE:  w = '{STL_OUT,  ACT_REL,   C_ALWAYS,      PC_ADVANCE, PC_ADVANCE};
            PC_ADVANCE:  w = '{STL_NONE, ACT_ADV,   C_LAST_ROW,    PC_FLUSH,   PC_READ};
            PC_CHECK:    w = '{STL_NONE, ACT_NOP,   C_EXHAUSTED,   PC_ADVANCE, PC_SEARCH};
            PC_FLUSH:    w = '{STL_OUT,  ACT_FLUSH, C_ALWAYS,      PC_IDLE,    PC_IDLE};
            default:     w = '{STL_NONE, ACT_NOP,   C_ALWAYS,      PC_IDLE,    PC_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/kmva_useq.sv */
// Microcode sequencer: step counter, program table, stall and branch selection.
`default_nettype none
module kmva_useq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire kmva_pkg::t_cond i_cond,
    output kmva_pkg::t_ctl      o_ctl
);

    logic [kmva_pkg::PC_W-1:0] r_pc;
    logic [kmva_pkg::PC_W-1:0] n_pc;
    kmva_pkg::t_uword          w;
    logic                      stall;
    logic                      taken;

    assign w = kmva_pkg::ucode(r_pc);

    always_comb begin
        case (w.stall)
            kmva_pkg::STL_IN:  stall = !i_cond.in_valid;
            kmva_pkg::STL_OUT: stall = i_cond.out_blocked;
            default:           stall = 1'b0;
        endcase
    end

    always_comb begin
        case (w.cond)
            kmva_pkg::C_BADCOL:      taken = i_cond.bad_col;
            kmva_pkg::C_PRESS_NEW:   taken = i_cond.press_new;
            kmva_pkg::C_RELEASE_OLD: taken = i_cond.release_old;
            kmva_pkg::C_CAND_FREE:   taken = i_cond.cand_free;
            kmva_pkg::C_EXHAUSTED:   taken = i_cond.exhausted;
            kmva_pkg::C_LAST_ROW:    taken = i_cond.last_row;
            default:                 taken = 1'b1;
        endcase
    end

    always_comb begin
        if (stall) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = w.t_true;
        end else begin
            n_pc = w.t_false;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= kmva_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.act  = w.act;
    assign o_ctl.fire = !stall;

endmodule
`default_nettype wire

/* rtl/core/key_matrix_voice_allocator_unit.sv */
// Top level: key matrix voice allocator with round-robin voice grant.
`default_nettype none
// Takes one scanned column per input item (column index and one pressed bit per row) and
// emits note-on / note-off events on the output stream, at most one per row, the final one
// of a scan flagged with tlast. A column out of range is taken and produces nothing. The
// block works on one column at a time under a microcoded sequencer; input ready is high
// only while it waits for a column. A press runs a round-robin search that steps over
// held voices; a press that finds every voice held emits no event. Output back-pressure
// stalls the block when a new event finds the previous one still waiting. Each event is
// held in a pending register until the next event or the end of the scan, so that tlast
// is known before it leaves. Ownership valid bits and the voice busy map are flip-flops
// cleared at reset; no clearing pass is needed.
module key_matrix_voice_allocator_unit #(
    parameter int NUM_VOICES  = 9,
    parameter int NUM_COLUMNS = 6,
    parameter int NUM_ROWS    = 7
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [6:0]  i_cfg_wdata,        // base_note
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,     // [2:0] column_index, [9:3] row_bits
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,     // [3:0] voice_index, [10:4] note_number
    output logic        o_m_axis_tuser,     // [0] event_kind
    output logic        o_m_axis_tlast
);

    localparam int NUM_KEYS = NUM_COLUMNS * NUM_ROWS;
    localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int VIDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W    = $clog2(NUM_VOICES + 1);
    localparam int SUM_W    = $clog2(NUM_KEYS + 128);
    localparam int NW       = kmva_pkg::NOTE_W;

    kmva_pkg::t_cond cond;
    kmva_pkg::t_ctl  ctl;

    logic [NW-1:0]     r_base;
    logic [6:0]        r_rows;
    logic [ROW_W-1:0]  r_row;
    logic [KEY_W-1:0]  r_key;
    logic [SUM_W-1:0]  r_sum;
    logic [VIDX_W-1:0] r_cand;
    logic [CNT_W-1:0]  r_cnt;
    logic [VIDX_W-1:0] r_last;
    logic [NUM_VOICES-1:0] r_busy;
    logic [NUM_KEYS-1:0]   r_own_vld;
    logic [VIDX_W-1:0] r_owner_mem [NUM_KEYS];
    logic [NW-1:0]     r_note_mem [NUM_KEYS];
    logic [VIDX_W-1:0] r_own_q;
    logic [NW-1:0]     r_note_q;

    logic              r_pend_valid;
    logic              r_pend_kind;
    logic [VIDX_W-1:0] r_pend_voice;
    logic [NW-1:0]     r_pend_note;
    logic              r_out_valid;
    logic              r_out_kind;
    logic [VIDX_W-1:0] r_out_voice;
    logic [NW-1:0]     r_out_note;
    logic              r_out_last;

    logic [2:0]        col_in;
    logic [7:0]        rows_ext;
    logic              pressed;
    logic [NW-1:0]     grant_note;
    logic              do_grant;
    logic              do_rel;
    logic              do_emit;
    logic              do_flush;
    logic              push_out;

    kmva_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctl   (ctl)
    );

    assign col_in   = i_s_axis_tdata[2:0];
    assign rows_ext = {1'b0, r_rows};
    assign pressed  = rows_ext[3'(r_row)];

    assign grant_note = (r_sum > SUM_W'(kmva_pkg::NOTE_MAX)) ? kmva_pkg::NOTE_MAX
                                                             : r_sum[NW-1:0];

    assign cond.in_valid    = i_s_axis_tvalid;
    assign cond.bad_col     = (32'(col_in) >= NUM_COLUMNS);
    assign cond.press_new   = !r_own_vld[r_key] && pressed;
    assign cond.release_old = r_own_vld[r_key] && !pressed;
    assign cond.cand_free   = !r_busy[r_cand];
    assign cond.exhausted   = (r_cnt == CNT_W'(NUM_VOICES));
    assign cond.last_row    = (r_row == ROW_W'(NUM_ROWS - 1));
    assign cond.out_blocked = r_pend_valid && r_out_valid;

    assign o_s_axis_tready = (ctl.act == kmva_pkg::ACT_LOAD);

    assign do_grant = ctl.fire && (ctl.act == kmva_pkg::ACT_GRANT);
    assign do_rel   = ctl.fire && (ctl.act == kmva_pkg::ACT_REL);
    assign do_flush = ctl.fire && (ctl.act == kmva_pkg::ACT_FLUSH);
    assign do_emit  = do_grant || do_rel;
    // the older pending event leaves whenever a newer one arrives or the scan ends
    assign push_out = (do_emit || do_flush) && r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= NW'(43);
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // scan walk: row, key address and running note sum
    always_ff @(posedge i_clk) begin
        if (ctl.fire) begin
            case (ctl.act)
                kmva_pkg::ACT_LOAD: begin
                    if (!cond.bad_col) begin
                        r_rows <= i_s_axis_tdata[9:3];
                        r_row  <= '0;
                        r_key  <= KEY_W'(32'(col_in) * NUM_ROWS);
                        r_sum  <= SUM_W'(col_in) + SUM_W'(r_base);
                    end
                end
                kmva_pkg::ACT_ADV: begin
                    if (!cond.last_row) begin
                        r_row <= r_row + 1'b1;
                        r_key <= r_key + 1'b1;
                        r_sum <= r_sum + SUM_W'(NUM_COLUMNS);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // round-robin search registers
    always_ff @(posedge i_clk) begin
        if (ctl.fire && ctl.act == kmva_pkg::ACT_INIT) begin
            r_cand <= (r_last == VIDX_W'(NUM_VOICES - 1)) ? '0 : r_last + 1'b1;
            r_cnt  <= '0;
        end else if (ctl.fire && ctl.act == kmva_pkg::ACT_STEP && !cond.cand_free) begin
            r_cand <= (r_cand == VIDX_W'(NUM_VOICES - 1)) ? '0 : r_cand + 1'b1;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_last    <= '0;
            r_own_vld <= '0;
        end else if (do_grant) begin
            r_busy[r_cand]   <= 1'b1;
            r_last           <= r_cand;
            r_own_vld[r_key] <= 1'b1;
        end else if (do_rel) begin
            r_busy[r_own_q]  <= 1'b0;
            r_own_vld[r_key] <= 1'b0;
        end
    end

    // per-key owner and note stores, registered read at the current key
    always_ff @(posedge i_clk) begin
        if (do_grant) begin
            r_owner_mem[r_key] <= r_cand;
            r_note_mem[r_key]  <= grant_note;
        end
        r_own_q  <= r_owner_mem[r_key];
        r_note_q <= r_note_mem[r_key];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (do_emit) begin
            r_pend_valid <= 1'b1;
        end else if (do_flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_grant) begin
            r_pend_kind  <= kmva_pkg::EV_NOTE_ON;
            r_pend_voice <= r_cand;
            r_pend_note  <= grant_note;
        end else if (do_rel) begin
            r_pend_kind  <= kmva_pkg::EV_NOTE_OFF;
            r_pend_voice <= r_own_q;
            r_pend_note  <= r_note_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_out) begin
            r_out_kind  <= r_pend_kind;
            r_out_voice <= r_pend_voice;
            r_out_note  <= r_pend_note;
            r_out_last  <= do_flush;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_note, kmva_pkg::VOICE_OUT_W'(r_out_voice)};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // every held voice belongs to exactly one key
    a_busy_matches_owners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_busy) == $countones(r_own_vld))
        else $error("voice busy map disagrees with key ownership");

    // a new column is only taken once the previous scan has flushed its last event
    a_ready_pend_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !r_pend_valid)
        else $error("input ready while an event is still pending");

    // an event shown without tlast always has a later one waiting behind it
    a_nonlast_has_follower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> r_pend_valid)
        else $error("non-final event without a following event");

endmodule
`default_nettype wire
